>>> sv/npdc_pkg.sv
// ----------------------------------------------------------------------------
// npdc_pkg
// Shared types, character codes and helper functions of the name cleaner.
// ----------------------------------------------------------------------------
`default_nettype none

package npdc_pkg;

    // Character codes that the decoder looks for.
    localparam logic [7:0] CH_PERCENT    = 8'h25;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TWO        = 8'h32;
    localparam logic [7:0] CH_THREE      = 8'h33;
    localparam logic [7:0] CH_EIGHT      = 8'h38;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_F    = 8'h46;

    // Most results that one bundle holds; further results of a beat are dropped.
    localparam int MAX_RESULTS = 3;
    localparam int RES_CW      = $clog2(MAX_RESULTS + 1);

    // Bundle queue between the front and back parts. Depth is a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Decoder phase, one-hot.
    typedef enum logic [3:0] {
        PH_TEXT = 4'b0001,
        PH_PCT  = 4'b0010,
        PH_DIG  = 4'b0100,
        PH_DONE = 4'b1000
    } phase_t;

    typedef struct packed {
        logic       has_byte;
        logic [7:0] out_byte;
    } result_t;

    // All results caused by one input beat.
    typedef struct packed {
        result_t [MAX_RESULTS-1:0] res;
        logic [RES_CW-1:0]         cnt;
        logic                      eon;
    } bundle_t;

    // Write side of the bundle queue.
    typedef struct packed {
        logic    push;
        bundle_t data;
    } queue_wr_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= CH_ZERO) && (c <= CH_NINE)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_F));
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
            v = c[3:0];
        end else if ((c >= CH_UPPER_A) && (c <= CH_UPPER_F)) begin
            v = 4'(c[3:0] + 4'd9);
        end
        return v;
    endfunction

    // Appends one result; results past the limit are dropped.
    function automatic bundle_t push_res(input bundle_t b, input logic [7:0] d,
                                         input logic has);
        bundle_t r;
        r = b;
        if (b.cnt != RES_CW'(MAX_RESULTS)) begin
            r.res[b.cnt].out_byte = d;
            r.res[b.cnt].has_byte = has;
            r.cnt = RES_CW'(b.cnt + 1'b1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/npdc_front.sv
// ----------------------------------------------------------------------------
// npdc_front
// Accepts raw bytes, runs the escape decoder and builds one result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

module npdc_front (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [7:0]          s_tdata,   // [7:0] ch
    input  wire logic                s_tlast,   // last
    input  wire logic                q_full,
    output npdc_pkg::queue_wr_t      q_wr
);

    npdc_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       first_digit_reg, first_digit_next;
    logic [7:0]       held_byte_reg, held_byte_next;
    logic             held_valid_reg, held_valid_next;
    npdc_pkg::bundle_t bundle;
    logic             s_fire;
    logic             c_is_pct;
    logic [7:0]       c_plain;

    assign s_tready = !q_full;
    assign s_fire   = s_tvalid && s_tready;
    assign c_is_pct = (s_tdata == npdc_pkg::CH_PERCENT);
    assign c_plain  = (s_tdata == npdc_pkg::CH_UNDERSCORE) ? npdc_pkg::CH_SPACE : s_tdata;

    always_comb begin
        npdc_pkg::bundle_t b;
        npdc_pkg::phase_t  ph;
        logic [7:0]        fd;
        logic [7:0]        hb;
        logic              hv;

        b   = '0;
        ph  = phase_reg;
        fd  = first_digit_reg;
        hb  = held_byte_reg;
        hv  = held_valid_reg;

        case (phase_reg)
            npdc_pkg::PH_TEXT: begin
                if (c_is_pct) begin
                    ph = npdc_pkg::PH_PCT;
                end else begin
                    if (hv) b = npdc_pkg::push_res(b, hb, 1'b1);
                    hb = c_plain;
                    hv = 1'b1;
                end
            end
            npdc_pkg::PH_PCT: begin
                if (npdc_pkg::is_hex(s_tdata)) begin
                    // Anything but '2' rules out the drop escape: free the held byte.
                    if (s_tdata != npdc_pkg::CH_TWO) begin
                        if (hv) b = npdc_pkg::push_res(b, hb, 1'b1);
                        hv = 1'b0;
                    end
                    fd = s_tdata;
                    ph = npdc_pkg::PH_DIG;
                end else begin
                    if (hv) b = npdc_pkg::push_res(b, hb, 1'b1);
                    hv = 1'b0;
                    b = npdc_pkg::push_res(b, npdc_pkg::CH_PERCENT, 1'b1);
                    if (c_is_pct) begin
                        ph = npdc_pkg::PH_PCT;
                    end else begin
                        ph = npdc_pkg::PH_TEXT;
                        hb = c_plain;
                        hv = 1'b1;
                    end
                end
            end
            npdc_pkg::PH_DIG: begin
                if (npdc_pkg::is_hex(s_tdata)) begin
                    if ((fd == npdc_pkg::CH_TWO) && (s_tdata == npdc_pkg::CH_EIGHT)) begin
                        hv = 1'b0;
                        ph = npdc_pkg::PH_DONE;
                    end else if ((fd == npdc_pkg::CH_TWO) &&
                                 (s_tdata == npdc_pkg::CH_THREE)) begin
                        if (hv) b = npdc_pkg::push_res(b, hb, 1'b1);
                        hv = 1'b0;
                        ph = npdc_pkg::PH_DONE;
                    end else begin
                        if (hv) b = npdc_pkg::push_res(b, hb, 1'b1);
                        hb = {npdc_pkg::hex_nibble(fd), npdc_pkg::hex_nibble(s_tdata)};
                        hv = 1'b1;
                        ph = npdc_pkg::PH_TEXT;
                    end
                end else begin
                    if (hv) b = npdc_pkg::push_res(b, hb, 1'b1);
                    hv = 1'b0;
                    b = npdc_pkg::push_res(b, npdc_pkg::CH_PERCENT, 1'b1);
                    b = npdc_pkg::push_res(b, fd, 1'b1);
                    if (c_is_pct) begin
                        ph = npdc_pkg::PH_PCT;
                    end else begin
                        ph = npdc_pkg::PH_TEXT;
                        hb = c_plain;
                        hv = 1'b1;
                    end
                end
            end
            npdc_pkg::PH_DONE: begin
                ph = npdc_pkg::PH_DONE;
            end
            default: begin
                ph = npdc_pkg::PH_DONE;
            end
        endcase

        if (s_tlast) begin
            // Flush whatever is still pending, then close the name.
            if (ph != npdc_pkg::PH_DONE) begin
                if (hv) b = npdc_pkg::push_res(b, hb, 1'b1);
            end
            if (ph == npdc_pkg::PH_PCT || ph == npdc_pkg::PH_DIG) begin
                b = npdc_pkg::push_res(b, npdc_pkg::CH_PERCENT, 1'b1);
            end
            if (ph == npdc_pkg::PH_DIG) begin
                b = npdc_pkg::push_res(b, fd, 1'b1);
            end
            if (b.cnt == '0) begin
                b = npdc_pkg::push_res(b, 8'd0, 1'b0);
            end
            b.eon = 1'b1;
            ph    = npdc_pkg::PH_TEXT;
            fd    = 8'd0;
            hb    = 8'd0;
            hv    = 1'b0;
        end

        bundle           = b;
        phase_next       = ph;
        first_digit_next = fd;
        held_byte_next   = hb;
        held_valid_next  = hv;
    end

    assign q_wr.push = s_fire && (bundle.cnt != '0);
    assign q_wr.data = bundle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= npdc_pkg::PH_TEXT;
            held_valid_reg <= 1'b0;
        end else if (s_fire) begin
            phase_reg      <= phase_next;
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            first_digit_reg <= first_digit_next;
            held_byte_reg   <= held_byte_next;
        end
    end

    // The closing beat of a name always queues a bundle marked as its end.
    a_last_pushes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast) |-> (q_wr.push && q_wr.data.eon))
        else $error("closing beat did not queue an end bundle");

    // After a name closes the decoder is back in plain text with nothing held.
    a_last_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tlast) |=> (phase_reg == npdc_pkg::PH_TEXT && !held_valid_reg))
        else $error("decoder state not cleared after end of name");

    // A byte held back is only ever present in plain text or an open escape.
    a_held_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        held_valid_reg |-> (phase_reg != npdc_pkg::PH_DONE))
        else $error("byte still held after the name ended");

endmodule

`default_nettype wire

>>> sv/npdc_queue.sv
// ----------------------------------------------------------------------------
// npdc_queue
// Short bundle queue that lets the front and back parts stall on their own.
// ----------------------------------------------------------------------------
`default_nettype none

module npdc_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire npdc_pkg::queue_wr_t  q_wr,
    output logic                      q_full,
    output logic                      q_valid,
    output npdc_pkg::bundle_t         q_data,
    input  wire logic                 q_pop
);

    npdc_pkg::bundle_t             mem_reg [npdc_pkg::QUEUE_DEPTH];
    logic [npdc_pkg::QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [npdc_pkg::QUEUE_CW-1:0] count_reg, count_next;
    logic                          do_push, do_pop;

    assign q_full  = (count_reg == npdc_pkg::QUEUE_CW'(npdc_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem_reg[rd_ptr_reg];
    assign do_push = q_wr.push && !q_full;
    assign do_pop  = q_pop && q_valid;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = npdc_pkg::QUEUE_CW'(count_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            count_next = npdc_pkg::QUEUE_CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= npdc_pkg::QUEUE_AW'(wr_ptr_reg + 1'b1);
            if (do_pop)  rd_ptr_reg <= npdc_pkg::QUEUE_AW'(rd_ptr_reg + 1'b1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= q_wr.data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_wr.push && q_full))
        else $error("bundle pushed into a full queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= npdc_pkg::QUEUE_CW'(npdc_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // After a push the queue is not empty on the next cycle.
    a_push_visible: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_wr.push && !q_full) |=> q_valid)
        else $error("queue empty right after a push");

endmodule

`default_nettype wire

>>> sv/npdc_back.sv
// ----------------------------------------------------------------------------
// npdc_back
// Takes bundles from the queue and sends their results one beat at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module npdc_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    input  wire npdc_pkg::bundle_t  q_data,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [7:0]              m_tdata,   // [7:0] out_byte
    output logic                    m_tuser,   // [0] has_byte
    output logic                    m_tlast    // end_of_name
);

    npdc_pkg::bundle_t             cur_reg;
    logic [npdc_pkg::RES_CW-1:0]   idx_reg;
    logic                          busy_reg;
    logic                          beat, last_idx, load;
    npdc_pkg::result_t             res_sel;

    assign last_idx = (idx_reg == npdc_pkg::RES_CW'(cur_reg.cnt - 1'b1));
    assign beat     = busy_reg && m_tready;
    assign load     = !busy_reg || (beat && last_idx);
    assign q_pop    = load && q_valid;

    assign res_sel  = cur_reg.res[idx_reg];
    assign m_tvalid = busy_reg;
    assign m_tdata  = res_sel.out_byte;
    assign m_tuser  = res_sel.has_byte;
    assign m_tlast  = cur_reg.eon && last_idx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (load) begin
            busy_reg <= q_valid;
            idx_reg  <= '0;
        end else if (beat) begin
            idx_reg  <= npdc_pkg::RES_CW'(idx_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load && q_valid) begin
            cur_reg <= q_data;
        end
    end

endmodule

`default_nettype wire

>>> sv/name_percent_decode_cleaner_top.sv
// ----------------------------------------------------------------------------
// name_percent_decode_cleaner_top
// Byte-stream name cleaner with percent-escape decoding.
// ----------------------------------------------------------------------------
// The block takes one raw name byte per beat on the s_ side and returns cleaned
// bytes on the m_ side. An underscore becomes a space, and a percent sign with
// two upper-case hex digits becomes the byte they encode. The escape %23 ends
// the name; %28 ends it and also drops the byte just before it, so one decoded
// byte is always held back until the next byte shows it is safe. Bytes after
// either escape are ignored until the beat with s_tlast. A malformed escape
// comes out literally. The beat with s_tlast always yields at least one result,
// and the last result of the name carries m_tlast; when no byte is due it is a
// bare marker with m_tuser (has_byte) low. Rate: the front part accepts one
// byte every cycle as long as the four-entry bundle queue has room, and each
// input beat turns into zero to three results. The output side sends one
// result per cycle while m_tready is high; sustained throughput is one byte
// per cycle on ordinary text. The results of a byte are written into the
// bundle queue and then loaded into the back part's bundle register before
// m_tvalid presents them.
// ----------------------------------------------------------------------------
`default_nettype none

module name_percent_decode_cleaner_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] ch
    input  wire logic        s_tlast,   // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic             m_tuser,   // [0] has_byte
    output logic             m_tlast    // end_of_name
);

    // Front to queue: bundle write; queue to back: head bundle.
    npdc_pkg::queue_wr_t q_wr;
    npdc_pkg::bundle_t   q_data;
    logic                q_full;
    logic                q_valid;
    logic                q_pop;

    // Decoder: classifies each byte and builds the bundle of results it causes.
    npdc_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_wr     (q_wr)
    );

    // Bundle queue decouples input stalls from output stalls.
    npdc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_wr     (q_wr),
        .q_full   (q_full),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    // Output serializer: one result per beat from the registered bundle.
    npdc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
